// File: design/sbet_pkg.sv
// ----------------------------------------------------------------------------
// sbet_pkg
// Shared types and constants of the slice binned extent tracker: coordinate
// type, queue item, empty box limits and fixed field widths.
// ----------------------------------------------------------------------------
package sbet_pkg;

	// Fixed field widths.
	localparam int COORD_W = 16;
	localparam int SLICE_W = 5;
	// Width of floor(z * 10) for a non-negative Q3.12 height.
	localparam int BIN_W = 7;
	// Number of fractional bits of the Q3.12 format.
	localparam int FRAC_W = 12;
	// Width of z * 10 for a non-negative 15 bit magnitude.
	localparam int PROD_W = 19;

	// Default number of height slices.
	localparam int SLICES_DEFAULT = 20;

	// Depth of the queue between the front and the back.
	localparam int QUEUE_DEPTH = 2;

	typedef logic signed [COORD_W-1:0] coord_t;

	// Limits that an empty bounding box reads as.
	localparam coord_t COORD_MAX = 16'sh7fff;
	localparam coord_t COORD_MIN = 16'sh8000;

	// One classified vertex, as the front hands it to the back.
	typedef struct packed {
		logic               start_of_mesh;
		logic               in_range;
		logic [SLICE_W-1:0] slice_index;
		coord_t             pos_x;
		coord_t             pos_y;
		coord_t             pos_z;
	} item_t;

endpackage

// File: design/sbet_ifs.sv
// ----------------------------------------------------------------------------
// sbet_ifs
// Valid/ready channels of the tracker: the vertex stream in and the extent
// results out.
// ----------------------------------------------------------------------------
interface sbet_vertex_if;
	logic            valid;
	logic            ready;
	logic            start_of_mesh;
	sbet_pkg::coord_t pos_x;
	sbet_pkg::coord_t pos_y;
	sbet_pkg::coord_t pos_z;

	modport source (output valid, start_of_mesh, pos_x, pos_y, pos_z, input ready);
	modport sink (input valid, start_of_mesh, pos_x, pos_y, pos_z, output ready);
endinterface

interface sbet_result_if;
	logic                         valid;
	logic                         ready;
	logic                         in_range;
	logic [sbet_pkg::SLICE_W-1:0] slice_index;
	sbet_pkg::coord_t             slice_x_high;
	sbet_pkg::coord_t             slice_x_low;
	sbet_pkg::coord_t             slice_y_high;
	sbet_pkg::coord_t             slice_y_low;
	sbet_pkg::coord_t             box_x_low;
	sbet_pkg::coord_t             box_x_high;
	sbet_pkg::coord_t             box_y_low;
	sbet_pkg::coord_t             box_y_high;
	sbet_pkg::coord_t             box_z_low;
	sbet_pkg::coord_t             box_z_high;

	modport source (
		output valid, in_range, slice_index, slice_x_high, slice_x_low,
		slice_y_high, slice_y_low, box_x_low, box_x_high, box_y_low,
		box_y_high, box_z_low, box_z_high,
		input ready
	);
	modport sink (
		input valid, in_range, slice_index, slice_x_high, slice_x_low,
		slice_y_high, slice_y_low, box_x_low, box_x_high, box_y_low,
		box_y_high, box_z_low, box_z_high,
		output ready
	);
endinterface

// File: design/sbet_front.sv
// ----------------------------------------------------------------------------
// sbet_front
// Accepts vertex beats and classifies them: works out the height slice
// floor(z * 10) and whether it lies in range, then pushes the item to the queue.
// ----------------------------------------------------------------------------
module sbet_front #(
	parameter int SLICES = sbet_pkg::SLICES_DEFAULT
) (
	sbet_vertex_if.sink        vertex,
	input  logic               queue_full,
	output logic               push,
	output sbet_pkg::item_t    push_item
);

	logic [sbet_pkg::PROD_W-1:0] height_x10;
	logic [sbet_pkg::BIN_W-1:0]  bin;
	logic                        in_range;

	// Accept whenever the queue has room.
	assign vertex.ready = !queue_full;
	assign push         = vertex.valid && !queue_full;

	// z * 10 as z * 8 + z * 2 on the non-negative magnitude.
	always_comb begin
		height_x10 = {1'b0, vertex.pos_z[sbet_pkg::COORD_W-2:0], 3'b000}
			+ {3'b000, vertex.pos_z[sbet_pkg::COORD_W-2:0], 1'b0};
		bin = height_x10[sbet_pkg::PROD_W-1:sbet_pkg::FRAC_W];
		// A negative height never lands in a slice.
		in_range = !vertex.pos_z[sbet_pkg::COORD_W-1]
			&& (bin < sbet_pkg::BIN_W'(SLICES));
	end

	// Build the queue item; out-of-range vertices carry slice zero.
	always_comb begin
		push_item.start_of_mesh = vertex.start_of_mesh;
		push_item.in_range      = in_range;
		push_item.slice_index   = in_range ? bin[sbet_pkg::SLICE_W-1:0] : '0;
		push_item.pos_x         = vertex.pos_x;
		push_item.pos_y         = vertex.pos_y;
		push_item.pos_z         = vertex.pos_z;
	end

endmodule

// File: design/sbet_queue.sv
// ----------------------------------------------------------------------------
// sbet_queue
// Short first-in first-out queue of classified items between the front and
// the back, so that each side can stall on its own.
// ----------------------------------------------------------------------------
module sbet_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  sbet_pkg::item_t push_item,
	output logic            full,
	input  logic            pop,
	output logic            head_valid,
	output sbet_pkg::item_t head_item
);

	localparam int PTR_W   = (sbet_pkg::QUEUE_DEPTH > 1) ? $clog2(sbet_pkg::QUEUE_DEPTH) : 1;
	localparam int COUNT_W = $clog2(sbet_pkg::QUEUE_DEPTH + 1);

	sbet_pkg::item_t    entries_q [sbet_pkg::QUEUE_DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [COUNT_W-1:0] count_q;

	assign full       = (count_q == COUNT_W'(sbet_pkg::QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head_item  = entries_q[rd_ptr_q];

	// Storage is written at the tail on every push.
	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_item;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(sbet_pkg::QUEUE_DEPTH - 1)) ? '0
					: wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(sbet_pkg::QUEUE_DEPTH - 1)) ? '0
					: rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + COUNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - COUNT_W'(1);
			end
		end
	end

endmodule

// File: design/sbet_back.sv
// ----------------------------------------------------------------------------
// sbet_back
// Carries out one classified vertex per cycle unless the result stalls:
// read-modify-write of slice extents and global box, and the result register.
// ----------------------------------------------------------------------------
module sbet_back #(
	parameter int SLICES = sbet_pkg::SLICES_DEFAULT
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            head_valid,
	input  sbet_pkg::item_t head_item,
	output logic            pop,
	sbet_result_if.source   result
);

	localparam int IDX_W = (SLICES > 1) ? $clog2(SLICES) : 1;

	// Slice extent stores; an entry only matters once its valid bit is set.
	sbet_pkg::coord_t xmax_mem [SLICES];
	sbet_pkg::coord_t xmin_mem [SLICES];
	sbet_pkg::coord_t ymax_mem [SLICES];
	sbet_pkg::coord_t ymin_mem [SLICES];
	logic [SLICES-1:0] slice_valid_q;

	// Global bounding box.
	sbet_pkg::coord_t box_x_low_q, box_x_high_q;
	sbet_pkg::coord_t box_y_low_q, box_y_high_q;
	sbet_pkg::coord_t box_z_low_q, box_z_high_q;

	logic             res_valid_q;

	logic [IDX_W-1:0] idx;
	logic             hit;
	sbet_pkg::coord_t px, py, pz;
	sbet_pkg::coord_t xmax_new, xmin_new, ymax_new, ymin_new;
	sbet_pkg::coord_t bxl, bxh, byl, byh, bzl, bzh;
	sbet_pkg::coord_t bxl_new, bxh_new, byl_new, byh_new, bzl_new, bzh_new;
	logic [SLICES-1:0] valid_next;

	// Take the next item whenever the result register is free or being drained.
	assign pop          = head_valid && (!res_valid_q || result.ready);
	assign result.valid = res_valid_q;

	// Slice update: a start of mesh or an unused slice loads the vertex itself.
	always_comb begin
		idx = head_item.slice_index[IDX_W-1:0];
		px  = head_item.pos_x;
		py  = head_item.pos_y;
		pz  = head_item.pos_z;
		hit = slice_valid_q[idx] && !head_item.start_of_mesh;

		xmax_new = (hit && (xmax_mem[idx] >= px)) ? xmax_mem[idx] : px;
		xmin_new = (hit && (xmin_mem[idx] <= px)) ? xmin_mem[idx] : px;
		ymax_new = (hit && (ymax_mem[idx] >= py)) ? ymax_mem[idx] : py;
		ymin_new = (hit && (ymin_mem[idx] <= py)) ? ymin_mem[idx] : py;

		valid_next = head_item.start_of_mesh ? '0 : slice_valid_q;
		if (head_item.in_range) begin
			valid_next[idx] = 1'b1;
		end
	end

	// Global box update: a start of mesh empties the box first.
	always_comb begin
		bxl = head_item.start_of_mesh ? sbet_pkg::COORD_MAX : box_x_low_q;
		bxh = head_item.start_of_mesh ? sbet_pkg::COORD_MIN : box_x_high_q;
		byl = head_item.start_of_mesh ? sbet_pkg::COORD_MAX : box_y_low_q;
		byh = head_item.start_of_mesh ? sbet_pkg::COORD_MIN : box_y_high_q;
		bzl = head_item.start_of_mesh ? sbet_pkg::COORD_MAX : box_z_low_q;
		bzh = head_item.start_of_mesh ? sbet_pkg::COORD_MIN : box_z_high_q;

		bxl_new = (head_item.in_range && (px < bxl)) ? px : bxl;
		bxh_new = (head_item.in_range && (px > bxh)) ? px : bxh;
		byl_new = (head_item.in_range && (py < byl)) ? py : byl;
		byh_new = (head_item.in_range && (py > byh)) ? py : byh;
		bzl_new = (head_item.in_range && (pz < bzl)) ? pz : bzl;
		bzh_new = (head_item.in_range && (pz > bzh)) ? pz : bzh;
	end

	// Slice extent stores are written for in-range vertices.
	always_ff @(posedge clk) begin
		if (pop && head_item.in_range) begin
			xmax_mem[idx] <= xmax_new;
			xmin_mem[idx] <= xmin_new;
			ymax_mem[idx] <= ymax_new;
			ymin_mem[idx] <= ymin_new;
		end
	end

	// Valid bits, global box and result valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slice_valid_q <= '0;
			box_x_low_q   <= sbet_pkg::COORD_MAX;
			box_x_high_q  <= sbet_pkg::COORD_MIN;
			box_y_low_q   <= sbet_pkg::COORD_MAX;
			box_y_high_q  <= sbet_pkg::COORD_MIN;
			box_z_low_q   <= sbet_pkg::COORD_MAX;
			box_z_high_q  <= sbet_pkg::COORD_MIN;
			res_valid_q   <= 1'b0;
		end else begin
			if (pop) begin
				slice_valid_q <= valid_next;
				box_x_low_q   <= bxl_new;
				box_x_high_q  <= bxh_new;
				box_y_low_q   <= byl_new;
				box_y_high_q  <= byh_new;
				box_z_low_q   <= bzl_new;
				box_z_high_q  <= bzh_new;
				res_valid_q   <= 1'b1;
			end else if (result.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// Result payload register; slice fields read zero when out of range.
	always_ff @(posedge clk) begin
		if (pop) begin
			result.in_range     <= head_item.in_range;
			result.slice_index  <= head_item.slice_index;
			result.slice_x_high <= head_item.in_range ? xmax_new : '0;
			result.slice_x_low  <= head_item.in_range ? xmin_new : '0;
			result.slice_y_high <= head_item.in_range ? ymax_new : '0;
			result.slice_y_low  <= head_item.in_range ? ymin_new : '0;
			result.box_x_low    <= bxl_new;
			result.box_x_high   <= bxh_new;
			result.box_y_low    <= byl_new;
			result.box_y_high   <= byh_new;
			result.box_z_low    <= bzl_new;
			result.box_z_high   <= bzh_new;
		end
	end

endmodule

// File: design/slice_binned_extent_tracker.sv
// ----------------------------------------------------------------------------
// slice_binned_extent_tracker
// Bins Q3.12 mesh vertices into height slices of 0.1 m and tracks the x/y
// extents of each slice together with the global x/y/z bounding box.
//
//   Channel   Direction  Beat contents
//   vertex    in         start_of_mesh, pos_x, pos_y, pos_z
//   result    out        in_range, slice_index, slice x/y extents, global box
//
// One vertex is accepted per cycle and one result beat follows it, while the
// result channel takes its beats; the slice read-modify-write in the back sets
// this rate. A result beat passes through the queue and then the result
// register after its vertex is accepted.
// Reset clears the slice valid bits and the global box at once; no sweep.
// A stalled result holds the back, and the two-entry queue then fills before
// the vertex channel drops ready.
// ----------------------------------------------------------------------------
module slice_binned_extent_tracker #(
	parameter int SLICES = sbet_pkg::SLICES_DEFAULT
) (
	input  logic          clk,
	input  logic          arst_n,
	sbet_vertex_if.sink   vertex,
	sbet_result_if.source result
);

	logic            queue_full;
	logic            push;
	sbet_pkg::item_t push_item;
	logic            pop;
	logic            head_valid;
	sbet_pkg::item_t head_item;

	// Classification of incoming vertices.
	sbet_front #(
		.SLICES(SLICES)
	) u_front (
		.vertex    (vertex),
		.queue_full(queue_full),
		.push      (push),
		.push_item (push_item)
	);

	// Decoupling queue.
	sbet_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (queue_full),
		.pop       (pop),
		.head_valid(head_valid),
		.head_item (head_item)
	);

	// Extent update and result register.
	sbet_back #(
		.SLICES(SLICES)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head_valid(head_valid),
		.head_item (head_item),
		.pop       (pop),
		.result    (result)
	);

endmodule

// File: tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the slice binned extent tracker. A driver sends
// vertex beats from a queue. A monitor predicts each result beat from its own
// copy of the slice extents and the global box, and compares every field of
// each result beat with the oldest prediction. Directed corner cases come
// first. Random meshes follow under three pacing phases.
// ----------------------------------------------------------------------------
module testbench;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int SLICE_COUNT = sbet_pkg::SLICES_DEFAULT;
	localparam int VERTICES_PER_PHASE = 660;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int TAIL_CYCLES = 8;

	// One vertex beat as the driver sends it.
	typedef struct packed {
		logic             start_of_mesh;
		sbet_pkg::coord_t pos_x;
		sbet_pkg::coord_t pos_y;
		sbet_pkg::coord_t pos_z;
	} vertex_t;

	// One predicted result beat.
	typedef struct packed {
		logic                         in_range;
		logic [sbet_pkg::SLICE_W-1:0] slice_index;
		sbet_pkg::coord_t             slice_x_high;
		sbet_pkg::coord_t             slice_x_low;
		sbet_pkg::coord_t             slice_y_high;
		sbet_pkg::coord_t             slice_y_low;
		sbet_pkg::coord_t             box_x_low;
		sbet_pkg::coord_t             box_x_high;
		sbet_pkg::coord_t             box_y_low;
		sbet_pkg::coord_t             box_y_high;
		sbet_pkg::coord_t             box_z_low;
		sbet_pkg::coord_t             box_z_high;
	} extent_beat_t;

	logic clk;
	logic arst_n;

	sbet_vertex_if vtx ();
	sbet_result_if res ();

	slice_binned_extent_tracker #(
		.SLICES(SLICE_COUNT)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.vertex (vtx),
		.result (res)
	);

	// Shadow copy of the tracker state.
	logic             slice_seen [SLICE_COUNT];
	sbet_pkg::coord_t slice_xhi [SLICE_COUNT];
	sbet_pkg::coord_t slice_xlo [SLICE_COUNT];
	sbet_pkg::coord_t slice_yhi [SLICE_COUNT];
	sbet_pkg::coord_t slice_ylo [SLICE_COUNT];
	sbet_pkg::coord_t box_lo [3];
	sbet_pkg::coord_t box_hi [3];

	vertex_t      vertices_pending [$];
	extent_beat_t extents_due [$];

	int vertices_queued = 0;
	int vertices_accepted = 0;
	int beats_checked = 0;
	int in_range_count = 0;
	int mesh_starts = 0;
	int mismatches = 0;
	int quiet_cycles = 0;
	int mesh_left = 0;
	int send_idle_pct = 33;
	int take_idle_pct = 64;

	// Clock with a 10 ns period.
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Apply one vertex to the shadow state and return the result beat it causes.
	function automatic extent_beat_t track_vertex(vertex_t v);
		extent_beat_t                  beat;
		logic [sbet_pkg::PROD_W-1:0]   height_x10;
		logic [sbet_pkg::BIN_W-1:0]    bin;
		sbet_pkg::coord_t              corner [3];
		int                            idx;
		if (v.start_of_mesh) begin
			for (int i = 0; i < SLICE_COUNT; i++)
				slice_seen[i] = 1'b0;
			for (int i = 0; i < 3; i++) begin
				box_lo[i] = sbet_pkg::COORD_MAX;
				box_hi[i] = sbet_pkg::COORD_MIN;
			end
		end
		// floor(z * 10) on the magnitude; a set sign bit is never in range.
		height_x10 = sbet_pkg::PROD_W'(v.pos_z[sbet_pkg::COORD_W-2:0])
			* sbet_pkg::PROD_W'(10);
		bin = sbet_pkg::BIN_W'(height_x10 >> sbet_pkg::FRAC_W);
		beat = '0;
		beat.in_range = !v.pos_z[sbet_pkg::COORD_W-1] && (int'(bin) < SLICE_COUNT);
		if (beat.in_range) begin
			idx = int'(bin);
			in_range_count++;
			if (!slice_seen[idx]) begin
				slice_seen[idx] = 1'b1;
				slice_xhi[idx] = v.pos_x;
				slice_xlo[idx] = v.pos_x;
				slice_yhi[idx] = v.pos_y;
				slice_ylo[idx] = v.pos_y;
			end else begin
				if (v.pos_x > slice_xhi[idx]) slice_xhi[idx] = v.pos_x;
				if (v.pos_x < slice_xlo[idx]) slice_xlo[idx] = v.pos_x;
				if (v.pos_y > slice_yhi[idx]) slice_yhi[idx] = v.pos_y;
				if (v.pos_y < slice_ylo[idx]) slice_ylo[idx] = v.pos_y;
			end
			corner[0] = v.pos_x;
			corner[1] = v.pos_y;
			corner[2] = v.pos_z;
			for (int i = 0; i < 3; i++) begin
				if (corner[i] < box_lo[i]) box_lo[i] = corner[i];
				if (corner[i] > box_hi[i]) box_hi[i] = corner[i];
			end
			beat.slice_index = bin[sbet_pkg::SLICE_W-1:0];
			beat.slice_x_high = slice_xhi[idx];
			beat.slice_x_low = slice_xlo[idx];
			beat.slice_y_high = slice_yhi[idx];
			beat.slice_y_low = slice_ylo[idx];
		end
		beat.box_x_low = box_lo[0];
		beat.box_x_high = box_hi[0];
		beat.box_y_low = box_lo[1];
		beat.box_y_high = box_hi[1];
		beat.box_z_low = box_lo[2];
		beat.box_z_high = box_hi[2];
		return beat;
	endfunction

	task automatic queue_vertex(logic start, sbet_pkg::coord_t x, sbet_pkg::coord_t y,
		sbet_pkg::coord_t z);
		vertex_t v;
		v.start_of_mesh = start;
		v.pos_x = x;
		v.pos_y = y;
		v.pos_z = z;
		vertices_pending.insert(vertices_pending.size(), v);
		vertices_queued++;
		if (start) mesh_starts++;
	endtask

	// Pick a coordinate: mostly full range, some near zero to provoke ties.
	function automatic sbet_pkg::coord_t pick_coord();
		if ($urandom_range(99) < 20)
			return sbet_pkg::coord_t'($urandom_range(8) - 4);
		return sbet_pkg::coord_t'($urandom);
	endfunction

	// Random meshes: each opens with a start beat, most heights fall in range.
	task automatic queue_random_meshes(int count);
		logic             start;
		sbet_pkg::coord_t z;
		int               pick;
		for (int i = 0; i < count; i++) begin
			if (mesh_left == 0) begin
				start = 1'b1;
				mesh_left = $urandom_range(120, 10);
			end else begin
				start = ($urandom_range(99) == 0);
				mesh_left--;
			end
			pick = $urandom_range(99);
			if (pick < 80)
				z = sbet_pkg::coord_t'($urandom_range(8191, 0));
			else if (pick < 90)
				z = sbet_pkg::coord_t'($urandom_range(32767, 8192));
			else
				z = sbet_pkg::coord_t'($urandom);
			queue_vertex(start, pick_coord(), pick_coord(), z);
		end
	endtask

	task automatic check_field(string name, int expected, int actual);
		if (expected != actual) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d",
				$realtime, name, expected, actual);
			mismatches++;
		end
	endtask

	// Vertex driver: a new beat goes out once the previous one is taken.
	always @(posedge clk or negedge arst_n) begin
		vertex_t next_vertex;
		if (!arst_n) begin
			vtx.valid <= 1'b0;
			vtx.start_of_mesh <= 1'b0;
			vtx.pos_x <= '0;
			vtx.pos_y <= '0;
			vtx.pos_z <= '0;
		end else if (!vtx.valid || vtx.ready) begin
			if (vertices_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				next_vertex = vertices_pending.pop_front();
				vtx.valid <= 1'b1;
				vtx.start_of_mesh <= next_vertex.start_of_mesh;
				vtx.pos_x <= next_vertex.pos_x;
				vtx.pos_y <= next_vertex.pos_y;
				vtx.pos_z <= next_vertex.pos_z;
			end else begin
				vtx.valid <= 1'b0;
			end
		end
	end

	// Result receiver: ready drops at random in the stalling phases.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res.ready <= 1'b0;
		end else begin
			res.ready <= ($urandom_range(99) >= take_idle_pct);
		end
	end

	// Monitor: predict on each vertex beat, check each result beat.
	always @(posedge clk) begin
		extent_beat_t due;
		vertex_t      seen;
		if (arst_n) begin
			if (vtx.valid && vtx.ready) begin
				seen.start_of_mesh = vtx.start_of_mesh;
				seen.pos_x = vtx.pos_x;
				seen.pos_y = vtx.pos_y;
				seen.pos_z = vtx.pos_z;
				extents_due.insert(extents_due.size(), track_vertex(seen));
				vertices_accepted++;
			end
			if (res.valid && res.ready) begin
				if (extents_due.size() == 0) begin
					$display("%0t: result beat with no prediction waiting", $realtime);
					mismatches++;
				end else begin
					due = extents_due.pop_front();
					beats_checked++;
					check_field("in_range", due.in_range, res.in_range);
					check_field("slice_index", due.slice_index, res.slice_index);
					check_field("slice_x_high", due.slice_x_high, res.slice_x_high);
					check_field("slice_x_low", due.slice_x_low, res.slice_x_low);
					check_field("slice_y_high", due.slice_y_high, res.slice_y_high);
					check_field("slice_y_low", due.slice_y_low, res.slice_y_low);
					check_field("box_x_low", due.box_x_low, res.box_x_low);
					check_field("box_x_high", due.box_x_high, res.box_x_high);
					check_field("box_y_low", due.box_y_low, res.box_y_low);
					check_field("box_y_high", due.box_y_high, res.box_y_high);
					check_field("box_z_low", due.box_z_low, res.box_z_low);
					check_field("box_z_high", due.box_z_high, res.box_z_high);
				end
			end
			// Watchdog on cycles without a beat on either channel.
			if ((vtx.valid && vtx.ready) || (res.valid && res.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: no beat for %0d cycles, %0d predictions outstanding",
					$realtime, WATCHDOG_LIMIT, extents_due.size());
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	// Stimulus and run control.
	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		ref_clear: begin
			for (int i = 0; i < SLICE_COUNT; i++)
				slice_seen[i] = 1'b0;
			for (int i = 0; i < 3; i++) begin
				box_lo[i] = sbet_pkg::COORD_MAX;
				box_hi[i] = sbet_pkg::COORD_MIN;
			end
		end

		// Directed: first vertex of a slice, extremes in slices 0 and 1, ties in slice 0.
		queue_vertex(1'b1, 16'sd0, 16'sd0, 16'sd0);
		queue_vertex(1'b0, sbet_pkg::COORD_MAX, sbet_pkg::COORD_MIN, 16'sd409);
		queue_vertex(1'b0, sbet_pkg::COORD_MIN, sbet_pkg::COORD_MAX, 16'sd410);
		queue_vertex(1'b0, sbet_pkg::COORD_MAX, sbet_pkg::COORD_MIN, 16'sd100);
		// Negative heights, the top edge of the top slice and heights above it.
		queue_vertex(1'b0, 16'sd7, 16'sd7, -16'sd1);
		queue_vertex(1'b0, 16'sd7, 16'sd7, sbet_pkg::COORD_MIN);
		queue_vertex(1'b0, 16'sd7, 16'sd7, sbet_pkg::COORD_MAX);
		queue_vertex(1'b0, 16'sd3, -16'sd3, 16'sd8191);
		queue_vertex(1'b0, 16'sd3, -16'sd3, 16'sd8192);
		// Start with an out-of-range vertex leaves the box empty.
		queue_vertex(1'b1, 16'sd1, 16'sd1, -16'sd5);
		queue_vertex(1'b1, 16'sd1, 16'sd1, 16'sd9000);
		queue_vertex(1'b0, -16'sd1, 16'sd1, 16'sd4096);
		queue_vertex(1'b0, 16'sd5, -16'sd5, 16'sd4096);
		queue_vertex(1'b0, 16'sd5, -16'sd5, 16'sd4096);
		// Start with an in-range vertex in the top slice.
		queue_vertex(1'b1, sbet_pkg::COORD_MIN, sbet_pkg::COORD_MIN, 16'sd8191);
		queue_vertex(1'b0, sbet_pkg::COORD_MAX, sbet_pkg::COORD_MAX, 16'sd8000);
		queue_vertex(1'b0, 16'sh5555, 16'sh2aaa, 16'sh1555);
		queue_vertex(1'b0, -16'sh5556, -16'sh2aab, 16'sh0aaa);
		queue_vertex(1'b0, 16'sd0, 16'sd0, 16'sd8192);

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Three pacing phases; the sender holds off until each one drains.
		for (int phase = 0; phase < 3; phase++) begin
			@(negedge clk);
			case (phase)
				0: begin
					send_idle_pct = 33;
					take_idle_pct = 64;
				end
				1: begin
					send_idle_pct = 64;
					take_idle_pct = 33;
				end
				default: begin
					send_idle_pct = 0;
					take_idle_pct = 0;
				end
			endcase
			queue_random_meshes(VERTICES_PER_PHASE);
			while (vertices_accepted != vertices_queued || extents_due.size() != 0)
				@(negedge clk);
		end

		repeat (TAIL_CYCLES) @(posedge clk);
		$display("Sent %0d vertices in %0d meshes, %0d of them inside a slice.",
			vertices_accepted, mesh_starts, in_range_count);
		$display("Checked %0d result beats under three pacing phases, %0d mismatches.",
			beats_checked, mismatches);
		if (mismatches == 0 && extents_due.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
